// ===== hw/rtl/irclt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irclt_pkg
// Shared types and constants for the IRC line tokeniser: parse phases,
// byte roles, delimiter characters and default limits.
// ----------------------------------------------------------------------------
package irclt_pkg;

    // Default limit on counted parameters per line
    localparam int MAX_PARAMS_DEF = 15;

    // Largest value the 4-bit index and total fields can carry
    localparam int FIELD_MAX = 15;

    // Delimiter characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Position within the current line
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SENDER = 3'd1,
        PH_CMD    = 3'd2,
        PH_PARAM  = 3'd3,
        PH_TEXT   = 3'd4
    } t_phase;

    // Role reported for each byte
    typedef enum logic [2:0] {
        ROLE_SENDER = 3'd0,
        ROLE_CMD    = 3'd1,
        ROLE_PARAM  = 3'd2,
        ROLE_TEXT   = 3'd3,
        ROLE_DELIM  = 3'd4
    } t_role;

endpackage

// ===== hw/rtl/irc_line_tokenizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_tokenizer_core
// Classifies each byte of an IRC line as sender, command, parameter,
// trailing text or delimiter, and reports per-line totals on the last byte.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+---------------------------------------
//   input   | i_in_valid / o_in_ready  | i_line_byte, i_line_last
//   output  | o_out_valid / i_out_ready| o_echo_byte, o_byte_role,
//           |                          | o_param_index, o_field_start,
//           |                          | o_line_done, o_param_total,
//           |                          | o_text_present, o_param_overflow
//
// One byte per clock sustained while the output is not stalled; each input
// transaction passes through the input register, then the result register.
// The single parse step between the two registers sets the rate.
// When the output is stalled the result register holds and the input
// register fills, after which o_in_ready drops.
// Synchronous active-low reset returns the parser to line start.
// ----------------------------------------------------------------------------
module irc_line_tokenizer_core #(
    parameter int MAX_PARAMS = irclt_pkg::MAX_PARAMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_line_byte,
    input  logic       i_line_last,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_echo_byte,
    output logic [2:0] o_byte_role,
    output logic [3:0] o_param_index,
    output logic       o_field_start,
    output logic       o_line_done,
    output logic [3:0] o_param_total,
    output logic       o_text_present,
    output logic       o_param_overflow
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam int EXT_W = (CNT_W + 1 > 5) ? CNT_W + 1 : 5;

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    // parser state
    irclt_pkg::t_phase r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_after_sep, n_after_sep;
    logic              r_ovf_seen, n_ovf_seen;
    logic              r_text_seen, n_text_seen;

    // result of the current byte
    irclt_pkg::t_role  n_role;
    logic [3:0]        n_pidx;
    logic              n_start;
    logic [3:0]        n_total;
    logic              n_text_out;
    logic              n_ovf_out;

    // result register
    logic              r_out_valid;
    logic [7:0]        r_echo;
    irclt_pkg::t_role  r_role;
    logic [3:0]        r_pidx;
    logic              r_start;
    logic              r_done;
    logic [3:0]        r_total;
    logic              r_text;
    logic              r_ovf;

    logic              w_adv;
    logic [EXT_W-1:0]  w_sum;
    logic [EXT_W-1:0]  w_sum_cap;

    // advance the parse stage when the result register is free or draining
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_adv;

    // capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_line_byte;
            r_in_last <= i_line_last;
        end
    end

    // next state and per-byte result
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_after_sep = r_after_sep;
        n_ovf_seen  = r_ovf_seen;
        n_text_seen = r_text_seen;
        n_role      = irclt_pkg::ROLE_DELIM;
        n_pidx      = 4'd0;
        n_start     = 1'b0;
        n_total     = 4'd0;
        n_text_out  = 1'b0;
        n_ovf_out   = 1'b0;
        w_sum       = '0;
        w_sum_cap   = '0;

        case (r_phase)
            irclt_pkg::PH_START: begin
                if (r_in_byte == irclt_pkg::CH_COLON) begin
                    n_phase     = irclt_pkg::PH_SENDER;
                    n_after_sep = 1'b1;
                end else if (r_in_byte == irclt_pkg::CH_SPACE) begin
                    n_phase     = irclt_pkg::PH_PARAM;
                    n_after_sep = 1'b1;
                end else begin
                    n_role      = irclt_pkg::ROLE_CMD;
                    n_start     = 1'b1;
                    n_phase     = irclt_pkg::PH_CMD;
                    n_after_sep = 1'b0;
                end
            end
            irclt_pkg::PH_SENDER: begin
                if (r_in_byte == irclt_pkg::CH_SPACE) begin
                    n_phase     = irclt_pkg::PH_CMD;
                    n_after_sep = 1'b1;
                end else begin
                    n_role      = irclt_pkg::ROLE_SENDER;
                    n_start     = r_after_sep;
                    n_after_sep = 1'b0;
                end
            end
            irclt_pkg::PH_CMD: begin
                if (r_in_byte == irclt_pkg::CH_SPACE) begin
                    n_phase     = irclt_pkg::PH_PARAM;
                    n_after_sep = 1'b1;
                end else begin
                    n_role      = irclt_pkg::ROLE_CMD;
                    n_start     = r_after_sep;
                    n_after_sep = 1'b0;
                end
            end
            irclt_pkg::PH_PARAM: begin
                if (r_in_byte == irclt_pkg::CH_SPACE) begin
                    // count the separator, saturating at the limit
                    if (r_cnt >= CNT_W'(MAX_PARAMS)) begin
                        n_ovf_seen = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_after_sep = 1'b1;
                end else if (r_in_byte == irclt_pkg::CH_COLON && r_after_sep) begin
                    n_phase     = irclt_pkg::PH_TEXT;
                    n_text_seen = 1'b1;
                end else begin
                    n_role      = irclt_pkg::ROLE_PARAM;
                    n_pidx      = (EXT_W'(r_cnt) > EXT_W'(irclt_pkg::FIELD_MAX)) ?
                                  4'(irclt_pkg::FIELD_MAX) : 4'(r_cnt);
                    n_start     = r_after_sep;
                    n_after_sep = 1'b0;
                end
            end
            default: begin
                n_role      = irclt_pkg::ROLE_TEXT;
                n_start     = r_after_sep;
                n_after_sep = 1'b0;
            end
        endcase

        // line totals on the last byte, then return to line start
        if (r_in_last) begin
            w_sum = EXT_W'(n_cnt) + EXT_W'(n_phase == irclt_pkg::PH_PARAM);
            n_ovf_out = n_ovf_seen;
            if (w_sum > EXT_W'(MAX_PARAMS)) begin
                w_sum_cap = EXT_W'(MAX_PARAMS);
                n_ovf_out = 1'b1;
            end else begin
                w_sum_cap = w_sum;
            end
            n_total = (w_sum_cap > EXT_W'(irclt_pkg::FIELD_MAX)) ?
                      4'(irclt_pkg::FIELD_MAX) : 4'(w_sum_cap);
            n_text_out  = n_text_seen;
            n_phase     = irclt_pkg::PH_START;
            n_cnt       = '0;
            n_after_sep = 1'b0;
            n_ovf_seen  = 1'b0;
            n_text_seen = 1'b0;
        end
    end

    // hold parser state; advance on each byte that moves to the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= irclt_pkg::PH_START;
            r_cnt       <= '0;
            r_after_sep <= 1'b0;
            r_ovf_seen  <= 1'b0;
            r_text_seen <= 1'b0;
        end else if (w_adv && r_in_valid) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_after_sep <= n_after_sep;
            r_ovf_seen  <= n_ovf_seen;
            r_text_seen <= n_text_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_adv && r_in_valid) begin
            r_echo  <= r_in_byte;
            r_role  <= n_role;
            r_pidx  <= n_pidx;
            r_start <= n_start;
            r_done  <= r_in_last;
            r_total <= n_total;
            r_text  <= n_text_out;
            r_ovf   <= n_ovf_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_echo_byte      = r_echo;
    assign o_byte_role      = r_role;
    assign o_param_index    = r_pidx;
    assign o_field_start    = r_start;
    assign o_line_done      = r_done;
    assign o_param_total    = r_total;
    assign o_text_present   = r_text;
    assign o_param_overflow = r_ovf;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for irc_line_tokenizer_core. A queue of line bytes is
// built up front (a few hand-picked lines, then random well-formed lines
// mixed with noise) and streamed in bursts through the input channel while
// the output channel stalls on its own pattern. Every accepted byte is run
// through a behavioural tokeniser and every result is compared field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PARAM_LIMIT  = irclt_pkg::MAX_PARAMS_DEF;
    localparam int RANDOM_ITEMS = 1150;

    // Receiver stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SPARSE = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_line_item;

    typedef struct packed {
        logic [7:0]       ch;
        irclt_pkg::t_role role;
        logic [3:0]       idx;
        logic             start;
        logic             done;
        logic [3:0]       total;
        logic             text;
        logic             ovf;
    } t_token;

    // DUT connections
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_line_byte = 8'h00;
    logic       i_line_last = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_echo_byte;
    logic [2:0] o_byte_role;
    logic [3:0] o_param_index;
    logic       o_field_start;
    logic       o_line_done;
    logic [3:0] o_param_total;
    logic       o_text_present;
    logic       o_param_overflow;

    // Stimulus and scoreboard storage
    t_line_item  pending_bytes[$];
    logic [7:0]  line_buf[$];
    t_token      expected_tokens[$];
    int          n_total    = 0;
    int          n_accepted = 0;
    int          n_errors   = 0;

    // Tokeniser state mirror
    irclt_pkg::t_phase tok_phase     = irclt_pkg::PH_START;
    int unsigned       tok_count     = 0;
    bit                tok_after_sep = 1'b0;
    bit                tok_ovf       = 1'b0;
    bit                tok_text      = 1'b0;

    // Driver and receiver bookkeeping
    logic        in_taken        = 1'b0;
    int          burst_left      = 0;
    int          gap_left        = 0;
    int          rx_mode         = RX_FREE;
    int          rx_mode_left    = 0;
    int unsigned rx_tick         = 0;
    t_line_item  next_item;
    t_token      predicted;
    t_token      oldest;

    irc_line_tokenizer_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_line_byte     (i_line_byte),
        .i_line_last     (i_line_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_echo_byte     (o_echo_byte),
        .o_byte_role     (o_byte_role),
        .o_param_index   (o_param_index),
        .o_field_start   (o_field_start),
        .o_line_done     (o_line_done),
        .o_param_total   (o_param_total),
        .o_text_present  (o_text_present),
        .o_param_overflow(o_param_overflow)
    );

    // 125 MHz clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advance the tokeniser by one byte and return the result it should give
    task automatic tokenize_byte(input logic [7:0] ch, input logic last, output t_token r);
        int unsigned sum;
        r       = '0;
        r.ch    = ch;
        r.role  = irclt_pkg::ROLE_DELIM;
        r.done  = last;
        case (tok_phase)
            irclt_pkg::PH_START: begin
                if (ch == irclt_pkg::CH_COLON) begin
                    tok_phase     = irclt_pkg::PH_SENDER;
                    tok_after_sep = 1'b1;
                end else if (ch == irclt_pkg::CH_SPACE) begin
                    tok_phase     = irclt_pkg::PH_PARAM;
                    tok_after_sep = 1'b1;
                end else begin
                    r.role        = irclt_pkg::ROLE_CMD;
                    r.start       = 1'b1;
                    tok_phase     = irclt_pkg::PH_CMD;
                    tok_after_sep = 1'b0;
                end
            end
            irclt_pkg::PH_SENDER: begin
                if (ch == irclt_pkg::CH_SPACE) begin
                    tok_phase     = irclt_pkg::PH_CMD;
                    tok_after_sep = 1'b1;
                end else begin
                    r.role        = irclt_pkg::ROLE_SENDER;
                    r.start       = tok_after_sep;
                    tok_after_sep = 1'b0;
                end
            end
            irclt_pkg::PH_CMD: begin
                if (ch == irclt_pkg::CH_SPACE) begin
                    tok_phase     = irclt_pkg::PH_PARAM;
                    tok_after_sep = 1'b1;
                end else begin
                    r.role        = irclt_pkg::ROLE_CMD;
                    r.start       = tok_after_sep;
                    tok_after_sep = 1'b0;
                end
            end
            irclt_pkg::PH_PARAM: begin
                if (ch == irclt_pkg::CH_SPACE) begin
                    // count saturates, further separators only flag overflow
                    if (tok_count >= PARAM_LIMIT)
                        tok_ovf = 1'b1;
                    else
                        tok_count++;
                    tok_after_sep = 1'b1;
                end else if (ch == irclt_pkg::CH_COLON && tok_after_sep) begin
                    tok_phase = irclt_pkg::PH_TEXT;
                    tok_text  = 1'b1;
                end else begin
                    r.role        = irclt_pkg::ROLE_PARAM;
                    r.idx         = (tok_count > irclt_pkg::FIELD_MAX) ?
                                    4'(irclt_pkg::FIELD_MAX) : 4'(tok_count);
                    r.start       = tok_after_sep;
                    tok_after_sep = 1'b0;
                end
            end
            default: begin
                r.role        = irclt_pkg::ROLE_TEXT;
                r.start       = tok_after_sep;
                tok_after_sep = 1'b0;
            end
        endcase

        // Line totals, then back to line start
        if (last) begin
            sum   = tok_count + ((tok_phase == irclt_pkg::PH_PARAM) ? 1 : 0);
            r.ovf = tok_ovf;
            if (sum > PARAM_LIMIT) begin
                sum   = PARAM_LIMIT;
                r.ovf = 1'b1;
            end
            if (sum > irclt_pkg::FIELD_MAX)
                sum = irclt_pkg::FIELD_MAX;
            r.total       = 4'(sum);
            r.text        = tok_text;
            tok_phase     = irclt_pkg::PH_START;
            tok_count     = 0;
            tok_after_sep = 1'b0;
            tok_ovf       = 1'b0;
            tok_text      = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Any byte except the two delimiters
    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255, 0));
        while (c == irclt_pkg::CH_SPACE || c == irclt_pkg::CH_COLON)
            c = 8'($urandom_range(255, 0));
        return c;
    endfunction

    // Random byte weighted towards delimiters
    function automatic logic [7:0] noise_byte();
        int sel;
        sel = $urandom_range(9, 0);
        if (sel < 3)
            return irclt_pkg::CH_SPACE;
        else if (sel < 5)
            return irclt_pkg::CH_COLON;
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic put_word(input int len);
        repeat (len) line_buf.push_back(word_byte());
    endtask

    // Move the line under construction into the pending queue, marking its end
    task automatic commit_line();
        t_line_item it;
        for (int k = 0; k < line_buf.size(); k++) begin
            it.ch   = line_buf[k];
            it.last = (k == line_buf.size() - 1);
            pending_bytes.push_back(it);
            n_total++;
        end
        line_buf.delete();
    endtask

    // One random line: mostly well formed, some pure noise
    task automatic gen_line();
        int n_par;
        int sel;
        if ($urandom_range(9, 0) < 2) begin
            repeat ($urandom_range(12, 1)) line_buf.push_back(noise_byte());
        end else begin
            // optional sender prefix, occasionally ending the line there
            if ($urandom_range(1, 0) == 1) begin
                line_buf.push_back(irclt_pkg::CH_COLON);
                put_word($urandom_range(6, 0));
                if ($urandom_range(19, 0) == 0) begin
                    commit_line();
                    return;
                end
                line_buf.push_back(irclt_pkg::CH_SPACE);
            end
            put_word($urandom_range(6, 0));

            // parameters, with many now and then to push past the limit
            sel = $urandom_range(9, 0);
            if (sel < 7)
                n_par = $urandom_range(4, 0);
            else if (sel < 9)
                n_par = $urandom_range(10, 5);
            else
                n_par = $urandom_range(19, 13);
            repeat (n_par) begin
                line_buf.push_back(irclt_pkg::CH_SPACE);
                if ($urandom_range(9, 0) == 0)
                    line_buf.push_back(irclt_pkg::CH_SPACE);
                put_word($urandom_range(5, 0));
                if ($urandom_range(9, 0) == 0)
                    line_buf.push_back(irclt_pkg::CH_COLON);
            end

            // trailing text may hold anything
            if ($urandom_range(9, 0) < 4) begin
                line_buf.push_back(irclt_pkg::CH_SPACE);
                line_buf.push_back(irclt_pkg::CH_COLON);
                repeat ($urandom_range(10, 0)) line_buf.push_back(noise_byte());
            end else if ($urandom_range(19, 0) == 0) begin
                line_buf.push_back(irclt_pkg::CH_SPACE);
            end
        end
        if (line_buf.size() == 0)
            line_buf.push_back(noise_byte());
        commit_line();
    endtask

    // Input driver: bursts of transactions with random gaps between them
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // hold the current transaction until it is taken
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (pending_bytes.size() > 0) begin
                next_item   = pending_bytes.pop_front();
                i_in_valid  <= 1'b1;
                i_line_byte <= next_item.ch;
                i_line_last <= next_item.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output receiver: switch between free running, random and sparse stalls
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(RX_SPARSE, RX_FREE);
            rx_mode_left <= $urandom_range(200, 20);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_FREE:   i_out_ready <= 1'b1;
            RX_RANDOM: i_out_ready <= 1'($urandom_range(1, 0));
            default:   i_out_ready <= (rx_tick[1:0] == 2'd0);
        endcase
        rx_tick <= rx_tick + 1;
    end

    // Predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                tokenize_byte(i_line_byte, i_line_last, predicted);
                expected_tokens.push_back(predicted);
                n_accepted <= n_accepted + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected result, echo_byte", o_echo_byte, -1);
                end else begin
                    oldest = expected_tokens.pop_front();
                    compare_field("echo_byte", o_echo_byte, oldest.ch);
                    compare_field("byte_role", o_byte_role, oldest.role);
                    compare_field("param_index", o_param_index, oldest.idx);
                    compare_field("field_start", o_field_start, oldest.start);
                    compare_field("line_done", o_line_done, oldest.done);
                    compare_field("param_total", o_param_total, oldest.total);
                    compare_field("text_present", o_text_present, oldest.text);
                    compare_field("param_overflow", o_param_overflow, oldest.ovf);
                end
            end
        end
    end

    // Build stimulus, run reset, wait for drain and report
    initial begin
        // line ends inside the sender
        line_buf.push_back(irclt_pkg::CH_COLON);
        line_buf.push_back("a");
        commit_line();
        // space as first byte: empty command, one empty parameter
        line_buf.push_back(irclt_pkg::CH_SPACE);
        commit_line();
        // empty sender, line ends inside the command
        line_buf.push_back(irclt_pkg::CH_COLON);
        line_buf.push_back(irclt_pkg::CH_SPACE);
        line_buf.push_back("C");
        commit_line();
        // lowest byte as command, text opened and left empty
        line_buf.push_back(8'h00);
        line_buf.push_back(irclt_pkg::CH_SPACE);
        line_buf.push_back(irclt_pkg::CH_COLON);
        commit_line();
        // highest byte as command, then more separators than the limit
        line_buf.push_back(8'hFF);
        repeat (16) line_buf.push_back(irclt_pkg::CH_SPACE);
        commit_line();

        while (n_total < 26 + RANDOM_ITEMS)
            gen_line();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/irclt_pkg.sv
hw/rtl/irc_line_tokenizer_core.sv
bench/tb_top.sv
